// File: hw/rtl/cbvmm_pkg.sv
// ----------------------------------------------------------------------------
// cbvmm_pkg - shared definitions for the bit-serial crossbar VMM
// Sizes, field widths, action codes, sequencer states and the control
// bundle that the sequencer broadcasts to the column cells.
// ----------------------------------------------------------------------------
package cbvmm_pkg;

    // Array geometry and input precision
    localparam int ROWS       = 64;
    localparam int COLS       = 16;
    localparam int INPUT_BITS = 8;

    // Fixed field widths
    localparam int ROW_W = 6;
    localparam int COL_W = 4;
    localparam int WGT_W = 9;
    localparam int VAL_W = 8;
    localparam int DOT_W = 32;

    // Derived widths
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_IW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int BIT_W  = (INPUT_BITS > 1) ? $clog2(INPUT_BITS) : 1;
    localparam int PART_W = WGT_W + INPUT_BITS;   // one weight times one input
    localparam int ACC_W  = 64;                   // running column sum

    // Action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // Weight clamp: the one code below the legal range maps to the minimum
    localparam logic signed [WGT_W-1:0] WGT_RAW_MIN = 9'sh100;
    localparam logic signed [WGT_W-1:0] WGT_MIN     = -9'sd255;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ACCUM,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                     mem_we;     // weight write
        logic                     mem_all;    // write every column (clear pass)
        logic [ROW_AW-1:0]        mem_addr;   // row for write or read
        logic [COL_W-1:0]         mem_col;    // column for a single write
        logic signed [WGT_W-1:0]  mem_wdata;
        logic                     rd_en;      // fetch weight row
        logic                     step;       // one bit-serial step
        logic                     first;      // first step of an item
        logic                     in_bit;     // input bit of this step
        logic                     accum;      // fold partial into accumulator
        logic                     finish;     // vector done: load drain, clear
        logic                     shift;      // advance the result chain
    } cell_ctrl_t;

endpackage

// File: hw/rtl/cbvmm_seq.sv
// ----------------------------------------------------------------------------
// cbvmm_seq - request sequencer
// Clears the weight store after reset, accepts load and compute requests,
// steps the input bits MSB first and counts the column results out.
// ----------------------------------------------------------------------------
module cbvmm_seq (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      action,
    input  logic [cbvmm_pkg::ROW_W-1:0]               row,
    input  logic [cbvmm_pkg::COL_W-1:0]               col,
    input  logic signed [cbvmm_pkg::WGT_W-1:0]        weight,
    input  logic [cbvmm_pkg::VAL_W-1:0]               value,
    input  logic                                      last,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [cbvmm_pkg::COL_W-1:0]               column,
    output logic                                      last_column,
    output cbvmm_pkg::cell_ctrl_t                     ctrl
);

    cbvmm_pkg::state_t                       state_reg, state_next;
    logic [cbvmm_pkg::ROW_AW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [cbvmm_pkg::BIT_W-1:0]             bit_cnt_reg, bit_cnt_next;
    logic [cbvmm_pkg::COL_IW-1:0]            col_cnt_reg, col_cnt_next;
    logic [cbvmm_pkg::INPUT_BITS-1:0]        value_reg, value_next;
    logic                                    last_reg, last_next;

    logic                                    row_ok;
    logic                                    col_ok;
    logic signed [cbvmm_pkg::WGT_W-1:0]      wgt_clamped;

    assign row_ok = (32'(row) < 32'(cbvmm_pkg::ROWS));
    assign col_ok = (32'(col) < 32'(cbvmm_pkg::COLS));
    assign wgt_clamped = (weight == cbvmm_pkg::WGT_RAW_MIN) ? cbvmm_pkg::WGT_MIN : weight;

    assign column      = cbvmm_pkg::COL_W'(col_cnt_reg);
    assign last_column = (32'(col_cnt_reg) == 32'(cbvmm_pkg::COLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cbvmm_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            bit_cnt_reg <= '0;
            col_cnt_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
            col_cnt_reg <= col_cnt_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        col_cnt_next = col_cnt_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        ctrl         = '0;

        case (state_reg)
            cbvmm_pkg::ST_CLEAR:
            begin
                // one weight row of every column per cycle
                ctrl.mem_we   = 1'b1;
                ctrl.mem_all  = 1'b1;
                ctrl.mem_addr = clr_cnt_reg;
                if (32'(clr_cnt_reg) == 32'(cbvmm_pkg::ROWS - 1))
                begin
                    state_next = cbvmm_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            cbvmm_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                ctrl.mem_addr = cbvmm_pkg::ROW_AW'(row);
                ctrl.mem_col  = col;
                ctrl.mem_wdata = wgt_clamped;
                if (in_valid)
                begin
                    if (action == cbvmm_pkg::ACT_LOAD)
                    begin
                        ctrl.mem_we = row_ok && col_ok;
                    end
                    else
                    begin
                        ctrl.rd_en   = 1'b1;
                        // an absent row contributes nothing
                        value_next   = row_ok ? cbvmm_pkg::INPUT_BITS'(value) : '0;
                        last_next    = last;
                        bit_cnt_next = cbvmm_pkg::BIT_W'(cbvmm_pkg::INPUT_BITS - 1);
                        state_next   = cbvmm_pkg::ST_CALC;
                    end
                end
            end

            cbvmm_pkg::ST_CALC:
            begin
                ctrl.step   = 1'b1;
                ctrl.first  = (32'(bit_cnt_reg) == 32'(cbvmm_pkg::INPUT_BITS - 1));
                ctrl.in_bit = value_reg[bit_cnt_reg];
                if (bit_cnt_reg == '0)
                begin
                    state_next = cbvmm_pkg::ST_ACCUM;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end

            cbvmm_pkg::ST_ACCUM:
            begin
                ctrl.accum  = 1'b1;
                ctrl.finish = last_reg;
                if (last_reg)
                begin
                    col_cnt_next = '0;
                    state_next   = cbvmm_pkg::ST_DRAIN;
                end
                else
                begin
                    state_next = cbvmm_pkg::ST_IDLE;
                end
            end

            cbvmm_pkg::ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.shift = 1'b1;
                    if (last_column)
                    begin
                        state_next = cbvmm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = cbvmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/cbvmm_cell.sv
// ----------------------------------------------------------------------------
// cbvmm_cell - one crossbar column
// Holds the column's weights, forms weight times input bit-serially, keeps
// the running column sum and one stage of the result shift chain.
// ----------------------------------------------------------------------------
module cbvmm_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cbvmm_pkg::cell_ctrl_t                  ctrl,
    input  logic                                   wr_sel,
    input  logic signed [cbvmm_pkg::DOT_W-1:0]     shift_in,
    output logic signed [cbvmm_pkg::DOT_W-1:0]     shift_out
);

    localparam int ACC_W = cbvmm_pkg::ACC_W;
    localparam int DOT_W = cbvmm_pkg::DOT_W;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DOT_W+1){1'b0}}, {(DOT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-DOT_W+1){1'b1}}, {(DOT_W-1){1'b0}}};

    logic signed [cbvmm_pkg::WGT_W-1:0]   mem [cbvmm_pkg::ROWS];
    logic signed [cbvmm_pkg::WGT_W-1:0]   wgt_reg;
    logic signed [cbvmm_pkg::PART_W-1:0]  part_reg, part_next;
    logic signed [ACC_W-1:0]              acc_reg, acc_next;
    logic signed [ACC_W-1:0]              sum;
    logic signed [DOT_W-1:0]              drain_reg, drain_next;
    logic signed [DOT_W-1:0]              sat_sum;

    // weight store, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_we && (ctrl.mem_all || wr_sel))
        begin
            mem[ctrl.mem_addr] <= ctrl.mem_wdata;
        end
        if (ctrl.rd_en)
        begin
            wgt_reg <= mem[ctrl.mem_addr];
        end
    end

    // MSB-first shift-and-add
    always_comb
    begin
        part_next = part_reg;
        if (ctrl.step)
        begin
            part_next = (ctrl.first ? '0 : (part_reg <<< 1))
                      + (ctrl.in_bit ? cbvmm_pkg::PART_W'(wgt_reg) : '0);
        end
    end

    assign sum = acc_reg + ACC_W'(part_reg);

    always_comb
    begin
        if (sum > SAT_HI)
        begin
            sat_sum = SAT_HI[DOT_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            sat_sum = SAT_LO[DOT_W-1:0];
        end
        else
        begin
            sat_sum = sum[DOT_W-1:0];
        end
    end

    always_comb
    begin
        acc_next   = acc_reg;
        drain_next = drain_reg;
        if (ctrl.accum)
        begin
            acc_next = ctrl.finish ? '0 : sum;
        end
        if (ctrl.finish)
        begin
            drain_next = sat_sum;
        end
        else if (ctrl.shift)
        begin
            drain_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg  <= part_next;
        drain_reg <= drain_next;
    end

    assign shift_out = drain_reg;

endmodule

// File: hw/rtl/crossbar_bit_serial_vmm.sv
// ----------------------------------------------------------------------------
// crossbar_bit_serial_vmm - bit-serial crossbar vector-matrix multiply
// A ROWS x COLS signed weight array and one column cell per column that
// accumulates input times weight, one input bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries two kinds of request:
//     action = load:    write weight (clamped to -255..255) at row/col.
//                       Out-of-range row or col is dropped.
//     action = compute: apply value to row; every column sum gains
//                       value * weight[row][col]. It runs as one weight
//                       fetch from each cell's row memory, INPUT_BITS
//                       shift-and-add steps in the cell's adder, and
//                       one fold into the column accumulator.
//   With last set on a compute request, the block then emits COLS results
//   on the output channel (out_valid/out_ready), column 0 first, one per
//   cycle while the receiver takes them. dot is the column sum saturated to
//   32 bits; last_column marks column COLS-1. The accumulators clear and a
//   new vector starts. The results leave through a shift chain across the
//   cells, so a stalled receiver simply holds the chain; no new request is
//   taken until the last column is delivered.
//   Reset: accumulators clear at once; the weight store is zeroed by a
//   clearing pass over all ROWS rows, during which in_ready stays low.
// ----------------------------------------------------------------------------
module crossbar_bit_serial_vmm (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic [cbvmm_pkg::ROW_W-1:0]            row,
    input  logic [cbvmm_pkg::COL_W-1:0]            col,
    input  logic signed [cbvmm_pkg::WGT_W-1:0]     weight,
    input  logic [cbvmm_pkg::VAL_W-1:0]            value,
    input  logic                                   last,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [cbvmm_pkg::COL_W-1:0]            column,
    output logic signed [cbvmm_pkg::DOT_W-1:0]     dot,
    output logic                                   last_column
);

    cbvmm_pkg::cell_ctrl_t                   ctrl;
    // chain[c] is the result held in cell c; chain[COLS] feeds zeros in
    logic signed [cbvmm_pkg::DOT_W-1:0]      chain [cbvmm_pkg::COLS+1];
    logic [cbvmm_pkg::COLS-1:0]              wr_sel;

    // Sequencer: clear pass, request intake, bit stepping, result count
    cbvmm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .row         (row),
        .col         (col),
        .weight      (weight),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .column      (column),
        .last_column (last_column),
        .ctrl        (ctrl)
    );

    assign chain[cbvmm_pkg::COLS] = '0;

    // Row of column cells; results shift toward cell 0 on each accepted result
    for (genvar c = 0; c < cbvmm_pkg::COLS; c++)
    begin : g_cell
        assign wr_sel[c] = (ctrl.mem_col == cbvmm_pkg::COL_W'(c));

        cbvmm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_sel    (wr_sel[c]),
            .shift_in  (chain[c+1]),
            .shift_out (chain[c])
        );
    end

    // Cell 0's result register drives the output directly
    assign dot = chain[0];

endmodule
